// ===== src/quaternion_trs_matrix_build_core_assert.svh =====
// ----------------------------------------------------------------------------
// quaternion trs matrix build assertion macros
// concurrent checks clocked on clk, off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TRS_MATRIX_BUILD_CORE_ASSERT_SVH
`define QUATERNION_TRS_MATRIX_BUILD_CORE_ASSERT_SVH

// same-cycle implication
`define QTMB_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define QTMB_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== src/qtmb_pkg.sv =====
// ----------------------------------------------------------------------------
// qtmb_pkg
// shared constants for the scale-rotate-translate matrix builder
// ----------------------------------------------------------------------------
package qtmb_pkg;

	localparam int QUAT_BITS_DEF  = 16;
	localparam int SCALE_BITS_DEF = 24;
	localparam int MOVE_BITS      = 32;
	localparam int LIMIT_BITS     = 32;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 32'd4;
	localparam int QE_MAX         = 30;
	localparam int NORM_W         = 64;
	localparam int DEN_W          = 32;
	localparam int QUOT_W         = DEN_W + 1;
	localparam int NUM_ENT        = 9;
	localparam int AXES           = 3;

endpackage

// ===== src/qtmb_recip_pipe.sv =====
// ----------------------------------------------------------------------------
// qtmb_recip_pipe
// pipelined restoring divider giving floor(2^63 / d) for d in [2^31, 2^32),
// one quotient bit per stage, side data travelling alongside
// ----------------------------------------------------------------------------
module qtmb_recip_pipe #(
	parameter int SIDE_W = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [qtmb_pkg::DEN_W-1:0]  in_den,
	input  logic [SIDE_W-1:0]           in_side,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [qtmb_pkg::QUOT_W-1:0] out_quot,
	output logic [SIDE_W-1:0]           out_side
);
	import qtmb_pkg::*;

	`include "quaternion_trs_matrix_build_core_assert.svh"

	localparam int STAGES = QUOT_W;
	localparam int LAST   = STAGES - 1;
	localparam logic [QUOT_W-1:0] REM_INIT = {2'b01, {(DEN_W-1){1'b0}}};
	localparam logic [DEN_W-1:0]  DEN_HALF = {1'b1, {(DEN_W-1){1'b0}}};

	logic [QUOT_W-1:0] rem_s  [STAGES];
	logic [DEN_W-1:0]  den_s  [STAGES];
	logic [QUOT_W-1:0] quo_s  [STAGES];
	logic [SIDE_W-1:0] side_s [STAGES];
	logic [STAGES-1:0] vld_s;
	logic [STAGES-1:0] rdy;

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [QUOT_W-1:0] r_in;
		logic [QUOT_W-1:0] r_sub;
		logic [DEN_W-1:0]  d_in;
		logic [QUOT_W-1:0] q_in;
		logic [SIDE_W-1:0] sd_in;
		logic              v_in;
		logic              ge;

		if (k == 0) begin : g_first
			assign r_in  = REM_INIT;
			assign d_in  = in_den;
			assign q_in  = '0;
			assign sd_in = in_side;
			assign v_in  = in_valid;
		end else begin : g_next
			assign r_in  = {rem_s[k-1][QUOT_W-2:0], 1'b0};
			assign d_in  = den_s[k-1];
			assign q_in  = quo_s[k-1];
			assign sd_in = side_s[k-1];
			assign v_in  = vld_s[k-1];
		end

		if (k == LAST) begin : g_last
			assign rdy[k] = !vld_s[k] || out_ready;
		end else begin : g_mid
			assign rdy[k] = !vld_s[k] || rdy[k+1];
		end

		assign ge    = r_in >= QUOT_W'(d_in);
		assign r_sub = r_in - QUOT_W'(d_in);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && v_in) begin
				rem_s[k]  <= ge ? r_sub : r_in;
				den_s[k]  <= d_in;
				quo_s[k]  <= {q_in[QUOT_W-2:0], ge};
				side_s[k] <= sd_in;
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[LAST];
	assign out_quot  = quo_s[LAST];
	assign out_side  = side_s[LAST];

	`QTMB_ASSERT_NOW(a_rem_bound, vld_s[LAST] && den_s[LAST][DEN_W-1],
		rem_s[LAST] < QUOT_W'(den_s[LAST]), "remainder not below divisor")
	`QTMB_ASSERT_NOW(a_quot_top, out_valid && out_quot[QUOT_W-1] && den_s[LAST][DEN_W-1],
		out_quot[QUOT_W-2:0] == '0, "quotient above 2^32")
	`QTMB_ASSERT_NOW(a_first_bit, vld_s[0] && den_s[0][DEN_W-1],
		quo_s[0][0] == (den_s[0] == DEN_HALF), "leading quotient bit wrong")

endmodule

// ===== src/quaternion_trs_matrix_build_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_trs_matrix_build_core
// scale-rotate-translate matrix from quaternion, scales and translation
// ----------------------------------------------------------------------------
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  cfg      | cfg_valid cfg_ready cfg_data          | write
//  in       | in_valid in_ready quat_* scale_* move_*| sink
//  out      | out_valid out_ready m11..m33 m41..m43 | source
//
//  one beat per cycle sustained while out_ready stays high; 5 front stages, 33 divider
//  stages of one quotient bit each, 4 multiply and rounding stages
//  reset sets the norm limit to 4 and empties every stage
//  each stage holds while the next is full and stalled; bubbles close up, so new beats
//  enter while a finished result waits on out_ready
// ----------------------------------------------------------------------------
module quaternion_trs_matrix_build_core #(
	parameter int QUAT_BITS  = qtmb_pkg::QUAT_BITS_DEF,
	parameter int SCALE_BITS = qtmb_pkg::SCALE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [qtmb_pkg::LIMIT_BITS-1:0]        cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [QUAT_BITS-1:0]            quat_x,
	input  logic signed [QUAT_BITS-1:0]            quat_y,
	input  logic signed [QUAT_BITS-1:0]            quat_z,
	input  logic signed [QUAT_BITS-1:0]            quat_w,
	input  logic signed [SCALE_BITS-1:0]           scale_x,
	input  logic signed [SCALE_BITS-1:0]           scale_y,
	input  logic signed [SCALE_BITS-1:0]           scale_z,
	input  logic signed [qtmb_pkg::MOVE_BITS-1:0]  move_x,
	input  logic signed [qtmb_pkg::MOVE_BITS-1:0]  move_y,
	input  logic signed [qtmb_pkg::MOVE_BITS-1:0]  move_z,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [SCALE_BITS-1:0]           m11,
	output logic signed [SCALE_BITS-1:0]           m12,
	output logic signed [SCALE_BITS-1:0]           m13,
	output logic signed [SCALE_BITS-1:0]           m21,
	output logic signed [SCALE_BITS-1:0]           m22,
	output logic signed [SCALE_BITS-1:0]           m23,
	output logic signed [SCALE_BITS-1:0]           m31,
	output logic signed [SCALE_BITS-1:0]           m32,
	output logic signed [SCALE_BITS-1:0]           m33,
	output logic signed [qtmb_pkg::MOVE_BITS-1:0]  m41,
	output logic signed [qtmb_pkg::MOVE_BITS-1:0]  m42,
	output logic signed [qtmb_pkg::MOVE_BITS-1:0]  m43
);
	import qtmb_pkg::*;

	`include "quaternion_trs_matrix_build_core_assert.svh"

	localparam int QDROP = (QUAT_BITS > QE_MAX) ? QUAT_BITS - QE_MAX : 0;
	localparam int QE    = QUAT_BITS - QDROP;
	localparam int PW    = 2 * QE;
	localparam int N2W   = 2 * QE + 1;
	localparam int NSW   = 2 * QE + 3;
	localparam int CMPW  = (N2W > LIMIT_BITS) ? N2W : LIMIT_BITS;
	localparam int ROT_F = ((63 - SCALE_BITS) < 30) ? (63 - SCALE_BITS) : 30;
	localparam int RW    = ROT_F + 1;
	localparam int MULW  = DEN_W + QUOT_W;
	localparam int PMW   = SCALE_BITS + RW;
	localparam logic [MULW-1:0]     RND_ROT = MULW'(1) << (62 - ROT_F);
	localparam logic [PMW-1:0]      RND_ENT = PMW'(1) << (ROT_F - 1);
	localparam logic [RW-1:0]       DIAG    = RW'(1) << ROT_F;
	localparam logic [SCALE_BITS:0] MAXPOS  = {2'b00, {(SCALE_BITS-1){1'b1}}};
	localparam logic [SCALE_BITS:0] MINMAG  = {2'b01, {(SCALE_BITS-1){1'b0}}};

	typedef struct packed {
		logic                              ident;
		logic [NUM_ENT-1:0]                nneg;
		logic [AXES-1:0][SCALE_BITS-1:0]   scl;
		logic [AXES-1:0][MOVE_BITS-1:0]    mv;
	} side_t;

	typedef struct packed {
		logic [NUM_ENT-1:0][DEN_W-1:0] a;
		side_t                         sd;
	} dside_t;

	typedef logic [NUM_ENT:0][NORM_W-1:0] nwords_t;

	localparam int SIDE_W = $bits(dside_t);

	function automatic nwords_t norm_step(input nwords_t wv, input int k);
		nwords_t r;
		r = wv;
		if ((wv[0] >> (NORM_W - k)) == '0) begin
			for (int i = 0; i <= NUM_ENT; i++) begin
				r[i] = wv[i] << k;
			end
		end
		return r;
	endfunction

	// configuration
	logic [LIMIT_BITS-1:0] limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	// stage ready chain
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	logic rdy_m1, rdy_m2, rdy_m3, rdy_m4;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic v_m1, v_m2, v_m3, v_m4;
	logic div_in_ready, div_out_valid;

	assign rdy_m4 = !v_m4 || out_ready;
	assign rdy_m3 = !v_m3 || rdy_m4;
	assign rdy_m2 = !v_m2 || rdy_m3;
	assign rdy_m1 = !v_m1 || rdy_m2;
	assign rdy_s5 = !v_s5 || div_in_ready;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_m3 <= 1'b0;
			v_m4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_m1) v_m1 <= div_out_valid;
			if (rdy_m2) v_m2 <= v_m1;
			if (rdy_m3) v_m3 <= v_m2;
			if (rdy_m4) v_m4 <= v_m3;
		end
	end

	// stage 1: quaternion products
	logic signed [QE-1:0] qx, qy, qz, qw;
	logic signed [PW-1:0] pxx_s1, pyy_s1, pzz_s1, pww_s1, pxy_s1;
	logic signed [PW-1:0] pxz_s1, pyz_s1, pxw_s1, pyw_s1, pzw_s1;
	logic [AXES-1:0][SCALE_BITS-1:0] scl_s1;
	logic [AXES-1:0][MOVE_BITS-1:0]  mv_s1;

	assign qx = QE'(quat_x >>> QDROP);
	assign qy = QE'(quat_y >>> QDROP);
	assign qz = QE'(quat_z >>> QDROP);
	assign qw = QE'(quat_w >>> QDROP);

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			pxx_s1 <= PW'(qx) * PW'(qx);
			pyy_s1 <= PW'(qy) * PW'(qy);
			pzz_s1 <= PW'(qz) * PW'(qz);
			pww_s1 <= PW'(qw) * PW'(qw);
			pxy_s1 <= PW'(qx) * PW'(qy);
			pxz_s1 <= PW'(qx) * PW'(qz);
			pyz_s1 <= PW'(qy) * PW'(qz);
			pxw_s1 <= PW'(qx) * PW'(qw);
			pyw_s1 <= PW'(qy) * PW'(qw);
			pzw_s1 <= PW'(qz) * PW'(qw);
			scl_s1 <= {scale_z, scale_y, scale_x};
			mv_s1  <= {move_z, move_y, move_x};
		end
	end

	// stage 2: squared norm, numerators, limit compare
	logic signed [NSW-1:0] exx, eyy, ezz, eww, exy, exz, eyz, exw, eyw, ezw;
	logic signed [NSW-1:0] num [NUM_ENT];
	logic [N2W-1:0]                n2_c;
	logic [NUM_ENT-1:0][N2W-1:0]   nm_c;
	logic [NUM_ENT-1:0]            nn_c;
	logic [N2W-1:0]                n2_s2;
	logic [NUM_ENT-1:0][N2W-1:0]   nm_s2;
	side_t                         sd_s2;

	assign exx = NSW'(pxx_s1);
	assign eyy = NSW'(pyy_s1);
	assign ezz = NSW'(pzz_s1);
	assign eww = NSW'(pww_s1);
	assign exy = NSW'(pxy_s1);
	assign exz = NSW'(pxz_s1);
	assign eyz = NSW'(pyz_s1);
	assign exw = NSW'(pxw_s1);
	assign eyw = NSW'(pyw_s1);
	assign ezw = NSW'(pzw_s1);

	always_comb begin
		n2_c   = N2W'(exx + eyy + ezz + eww);
		num[0] = eww + exx - eyy - ezz;
		num[1] = (exy + ezw) <<< 1;
		num[2] = (exz - eyw) <<< 1;
		num[3] = (exy - ezw) <<< 1;
		num[4] = eww - exx + eyy - ezz;
		num[5] = (eyz + exw) <<< 1;
		num[6] = (exz + eyw) <<< 1;
		num[7] = (eyz - exw) <<< 1;
		num[8] = eww - exx - eyy + ezz;
		for (int i = 0; i < NUM_ENT; i++) begin
			nn_c[i] = num[i][NSW-1];
			nm_c[i] = N2W'(num[i][NSW-1] ? -num[i] : num[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			n2_s2       <= n2_c;
			nm_s2       <= nm_c;
			sd_s2.ident <= CMPW'(n2_c) <= CMPW'(limit_q);
			sd_s2.nneg  <= nn_c;
			sd_s2.scl   <= scl_s1;
			sd_s2.mv    <= mv_s1;
		end
	end

	// stages 3 to 5: normalise the norm to [2^63, 2^64), numerators alike
	nwords_t w_in, w_s3, w_s4, w_s5;
	side_t   sd_s3, sd_s4, sd_s5;

	always_comb begin
		w_in[0] = NORM_W'(n2_s2);
		for (int i = 0; i < NUM_ENT; i++) begin
			w_in[i+1] = NORM_W'(nm_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			w_s3  <= norm_step(norm_step(w_in, 32), 16);
			sd_s3 <= sd_s2;
		end
		if (rdy_s4 && v_s3) begin
			w_s4  <= norm_step(norm_step(w_s3, 8), 4);
			sd_s4 <= sd_s3;
		end
		if (rdy_s5 && v_s4) begin
			w_s5  <= norm_step(norm_step(w_s4, 2), 1);
			sd_s5 <= sd_s4;
		end
	end

	// reciprocal of the normalised norm
	dside_t              div_in, div_out;
	logic [QUOT_W-1:0]   recip;
	logic [SIDE_W-1:0]   div_out_vec;

	always_comb begin
		div_in.sd = sd_s5;
		for (int i = 0; i < NUM_ENT; i++) begin
			div_in.a[i] = w_s5[i+1][NORM_W-1 -: DEN_W];
		end
	end

	qtmb_recip_pipe #(
		.SIDE_W (SIDE_W)
	) u_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_ready  (div_in_ready),
		.in_den    (w_s5[0][NORM_W-1 -: DEN_W]),
		.in_side   (div_in),
		.out_valid (div_out_valid),
		.out_ready (rdy_m1),
		.out_quot  (recip),
		.out_side  (div_out_vec)
	);

	assign div_out = dside_t'(div_out_vec);

	// stage m1: numerator times reciprocal
	logic [NUM_ENT-1:0][MULW-1:0] prod_m1;
	side_t                        sd_m1;

	always_ff @(posedge clk) begin
		if (rdy_m1 && div_out_valid) begin
			for (int i = 0; i < NUM_ENT; i++) begin
				prod_m1[i] <= MULW'(div_out.a[i]) * MULW'(recip);
			end
			sd_m1 <= div_out.sd;
		end
	end

	// stage m2: rounded rotation magnitude
	logic [NUM_ENT-1:0][MULW-1:0] rsum;
	logic [NUM_ENT-1:0][RW-1:0]   rmag_c;
	logic [NUM_ENT-1:0][RW-1:0]   rmag_m2;
	logic [NUM_ENT-1:0]           nr_m2;
	side_t                        sd_m2;
	logic                         rmag_ok;

	always_comb begin
		for (int i = 0; i < NUM_ENT; i++) begin
			rsum[i] = prod_m1[i] + RND_ROT;
			if (sd_m1.ident) begin
				rmag_c[i] = ((i % 4) == 0) ? DIAG : '0;
			end else begin
				rmag_c[i] = RW'(rsum[i] >> (63 - ROT_F));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_m2 && v_m1) begin
			rmag_m2 <= rmag_c;
			nr_m2   <= sd_m1.ident ? '0 : sd_m1.nneg;
			sd_m2   <= sd_m1;
		end
	end

	always_comb begin
		rmag_ok = 1'b1;
		for (int i = 0; i < NUM_ENT; i++) begin
			if (rmag_m2[i] > DIAG) rmag_ok = 1'b0;
		end
	end

	// stage m3: scale magnitude times rotation magnitude
	logic [AXES-1:0][SCALE_BITS-1:0] smag;
	logic [NUM_ENT-1:0][PMW-1:0]     pmr_m3;
	logic [NUM_ENT-1:0]              nr_m3;
	side_t                           sd_m3;

	always_comb begin
		for (int j = 0; j < AXES; j++) begin
			smag[j] = sd_m2.scl[j][SCALE_BITS-1] ? SCALE_BITS'(-sd_m2.scl[j]) : sd_m2.scl[j];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_m3 && v_m2) begin
			for (int i = 0; i < NUM_ENT; i++) begin
				pmr_m3[i] <= PMW'(smag[i / 3]) * PMW'(rmag_m2[i]);
			end
			nr_m3 <= nr_m2;
			sd_m3 <= sd_m2;
		end
	end

	// stage m4: round half away from zero, sign, saturate
	logic [NUM_ENT-1:0][SCALE_BITS:0]   pm;
	logic [NUM_ENT-1:0][SCALE_BITS:0]   pcap;
	logic [NUM_ENT-1:0]                 eneg;
	logic [NUM_ENT-1:0][SCALE_BITS-1:0] ent_c;
	logic [NUM_ENT-1:0][SCALE_BITS-1:0] ent_m4;
	side_t                              sd_m4;

	always_comb begin
		for (int i = 0; i < NUM_ENT; i++) begin
			pm[i]   = (SCALE_BITS+1)'((pmr_m3[i] + RND_ENT) >> ROT_F);
			eneg[i] = (nr_m3[i] ^ sd_m3.scl[i / 3][SCALE_BITS-1]) && (pm[i] != '0);
			if (eneg[i]) begin
				pcap[i]  = (pm[i] > MINMAG) ? MINMAG : pm[i];
				ent_c[i] = SCALE_BITS'(-pcap[i]);
			end else begin
				pcap[i]  = (pm[i] > MAXPOS) ? MAXPOS : pm[i];
				ent_c[i] = SCALE_BITS'(pcap[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_m4 && v_m3) begin
			ent_m4 <= ent_c;
			sd_m4  <= sd_m3;
		end
	end

	assign out_valid = v_m4;
	assign m11 = ent_m4[0];
	assign m12 = ent_m4[1];
	assign m13 = ent_m4[2];
	assign m21 = ent_m4[3];
	assign m22 = ent_m4[4];
	assign m23 = ent_m4[5];
	assign m31 = ent_m4[6];
	assign m32 = ent_m4[7];
	assign m33 = ent_m4[8];
	assign m41 = sd_m4.mv[0];
	assign m42 = sd_m4.mv[1];
	assign m43 = sd_m4.mv[2];

	`QTMB_ASSERT_NOW(a_norm_msb, v_s5 && !sd_s5.ident,
		w_s5[0][NORM_W-1], "norm not normalised")
	`QTMB_ASSERT_NOW(a_rmag_bound, v_m2, rmag_ok, "rotation magnitude above one")
	`QTMB_ASSERT_NOW(a_ident_offdiag, out_valid && sd_m4.ident,
		m12 == '0 && m13 == '0 && m21 == '0 && m23 == '0 && m31 == '0 && m32 == '0,
		"identity rotation gave off-diagonal terms")

endmodule

// ===== dv/quaternion_trs_matrix_build_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_trs_matrix_build_core_tb
// drives quaternion, scale and translation beats into the matrix builder and
// checks every matrix against an in-bench fixed-point predictor; covers the
// small-norm identity path, saturation, several norm limits, random stalls on
// both sides and a long output hold that backs the pipeline up
// ----------------------------------------------------------------------------
module quaternion_trs_matrix_build_core_tb;
	import qtmb_pkg::*;

	localparam int QB = QUAT_BITS_DEF;
	localparam int SB = SCALE_BITS_DEF;
	localparam int ROT_F = (63 - SB) < 30 ? (63 - SB) : 30;
	localparam int DRAIN_CYCLES = 60;
	localparam int STUCK_LIMIT = 5000;
	localparam logic signed [SB-1:0] SCALE_MIN = {1'b1, {(SB-1){1'b0}}};
	localparam logic signed [SB-1:0] SCALE_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [QB-1:0] QONE = QB'(1 << (QB - 2));

	typedef struct {
		logic signed [QB-1:0] q[4];
		logic signed [SB-1:0] s[3];
		logic signed [MOVE_BITS-1:0] mv[3];
	} xform_t;

	typedef struct {
		logic [SB-1:0] ent[NUM_ENT];
		logic [MOVE_BITS-1:0] mv[3];
	} matrix_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [LIMIT_BITS-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [QB-1:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
	logic signed [SB-1:0] scale_x = '0, scale_y = '0, scale_z = '0;
	logic signed [MOVE_BITS-1:0] move_x = '0, move_y = '0, move_z = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [SB-1:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;
	logic signed [MOVE_BITS-1:0] m41, m42, m43;

	matrix_t pending_matrices[$];
	logic [LIMIT_BITS-1:0] norm_limit = LIMIT_RESET;
	bit send_gaps = 0;
	bit recv_stalls = 0;
	int hold_request = 0;
	int stall_left = 0;
	int errors = 0;
	int beats_in = 0;
	int beats_out = 0;
	int identity_hits = 0;
	int cfg_writes = 0;
	int stuck_cycles = 0;
	string ent_names[NUM_ENT] = '{"m11", "m12", "m13", "m21", "m22", "m23",
		"m31", "m32", "m33"};
	string move_names[3] = '{"m41", "m42", "m43"};

	quaternion_trs_matrix_build_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
		.scale_x(scale_x), .scale_y(scale_y), .scale_z(scale_z),
		.move_x(move_x), .move_y(move_y), .move_z(move_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.m11(m11), .m12(m12), .m13(m13), .m21(m21), .m22(m22), .m23(m23),
		.m31(m31), .m32(m32), .m33(m33), .m41(m41), .m42(m42), .m43(m43)
	);

	always #1 clk = ~clk;

	function automatic logic [SB-1:0] scaled_entry(longint sc, longint num, bit ident,
			bit diag, int rsh, int lsh, bit [63:0] recip);
		bit [63:0] a, rmag, pm, maxpos, smag;
		bit neg;
		if (ident) begin
			rmag = diag ? (64'd1 << ROT_F) : 64'd0;
			neg = 0;
		end else begin
			a = num < 0 ? -num : num;
			a = (a >> rsh) << lsh;
			rmag = (a * recip + (64'd1 << (62 - ROT_F))) >> (63 - ROT_F);
			neg = num < 0;
		end
		smag = sc < 0 ? -sc : sc;
		pm = (smag * rmag + (64'd1 << (ROT_F - 1))) >> ROT_F;
		neg = (neg != (sc < 0)) && pm != 0;
		maxpos = (64'd1 << (SB - 1)) - 1;
		if (neg) begin
			if (pm > maxpos + 1)
				pm = maxpos + 1;
			pm = -pm;
		end else if (pm > maxpos) begin
			pm = maxpos;
		end
		return pm[SB-1:0];
	endfunction

	function automatic matrix_t build_matrix(xform_t t, logic [LIMIT_BITS-1:0] lim,
			output bit ident);
		matrix_t m;
		longint x, y, z, w;
		longint num[NUM_ENT];
		bit [63:0] n2, d, recip;
		int rsh, lsh;
		x = t.q[0];
		y = t.q[1];
		z = t.q[2];
		w = t.q[3];
		n2 = x * x + y * y + z * z + w * w;
		ident = n2 <= {32'd0, lim};
		num[0] = w * w + x * x - y * y - z * z;
		num[1] = 2 * (x * y + z * w);
		num[2] = 2 * (x * z - y * w);
		num[3] = 2 * (x * y - z * w);
		num[4] = w * w - x * x + y * y - z * z;
		num[5] = 2 * (y * z + x * w);
		num[6] = 2 * (x * z + y * w);
		num[7] = 2 * (y * z - x * w);
		num[8] = w * w - x * x - y * y + z * z;
		d = n2;
		rsh = 0;
		lsh = 0;
		recip = 0;
		if (!ident) begin
			while (d >= (64'd1 << 32)) begin
				d = d >> 1;
				rsh++;
			end
			while (d < (64'd1 << 31)) begin
				d = d << 1;
				lsh++;
			end
			recip = (64'd1 << 63) / d;
		end
		for (int i = 0; i < NUM_ENT; i++)
			m.ent[i] = scaled_entry(t.s[i / 3], num[i], ident, (i % 4) == 0, rsh, lsh, recip);
		for (int i = 0; i < 3; i++)
			m.mv[i] = t.mv[i];
		return m;
	endfunction

	task automatic send_xform(xform_t t);
		matrix_t m;
		bit ident;
		if (send_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1;
		quat_x <= t.q[0];
		quat_y <= t.q[1];
		quat_z <= t.q[2];
		quat_w <= t.q[3];
		scale_x <= t.s[0];
		scale_y <= t.s[1];
		scale_z <= t.s[2];
		move_x <= t.mv[0];
		move_y <= t.mv[1];
		move_z <= t.mv[2];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		m = build_matrix(t, norm_limit, ident);
		identity_hits += ident;
		pending_matrices.insert(pending_matrices.size(), m);
		beats_in++;
	endtask

	task automatic end_burst();
		in_valid <= 0;
	endtask

	task automatic drain();
		while (pending_matrices.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_BITS-1:0] v);
		drain();
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		norm_limit = v;
		cfg_writes++;
	endtask

	function automatic xform_t make_xform(int qx, int qy, int qz, int qw,
			logic signed [SB-1:0] sx, logic signed [SB-1:0] sy, logic signed [SB-1:0] sz);
		xform_t t;
		t.q = '{QB'(qx), QB'(qy), QB'(qz), QB'(qw)};
		t.s = '{sx, sy, sz};
		t.mv = '{$urandom, $urandom, $urandom};
		return t;
	endfunction

	function automatic logic signed [SB-1:0] rand_scale();
		case ($urandom_range(0, 5))
			0: return SCALE_MIN;
			1: return SCALE_MAX;
			2: return $urandom_range(0, 1) ? 24'sh010000 : -24'sh010000;
			default: return SB'($urandom);
		endcase
	endfunction

	function automatic logic signed [QB-1:0] near(int centre, int spread);
		return QB'(centre + int'($urandom_range(0, 2 * spread)) - spread);
	endfunction

	function automatic xform_t rand_xform();
		xform_t t;
		int kind;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 4; i++) begin
			case (kind)
				0, 1, 2: t.q[i] = QB'($urandom);
				3: t.q[i] = QB'($urandom_range(0, 7) - 3);
				4: t.q[i] = i == $urandom_range(0, 3) ? QONE : 16'sd0;
				default: t.q[i] = $signed(16'($urandom_range(0, 2 * QONE))) - QONE / 2;
			endcase
		end
		if (kind == 9)
			t.q = '{near(QONE / 2, 8), near(-QONE / 2, 8), near(QONE / 2, 8), near(QONE / 2, 8)};
		for (int i = 0; i < 3; i++)
			t.s[i] = rand_scale();
		t.mv = '{$urandom, $urandom, $urandom};
		return t;
	endfunction

	task automatic test_directed();
		xform_t t[$];
		t.insert(t.size(), make_xform(0, 0, 0, 0, SCALE_MAX, SCALE_MIN, 24'sh010000));
		t.insert(t.size(), make_xform(0, 0, 0, QONE, 24'sh010000, 24'sh020000,
			-24'sh010000));
		t.insert(t.size(), make_xform(QONE, 0, 0, 0, SCALE_MIN, SCALE_MIN, SCALE_MIN));
		t.insert(t.size(), make_xform(0, QONE, 0, 0, SCALE_MIN, SCALE_MAX, SCALE_MIN));
		t.insert(t.size(), make_xform(0, 0, QONE, 0, SCALE_MAX, SCALE_MIN, SCALE_MIN));
		t.insert(t.size(), make_xform(32767, 32767, 32767, 32767, SCALE_MAX, SCALE_MAX,
			SCALE_MAX));
		t.insert(t.size(), make_xform(-32768, -32768, -32768, -32768, SCALE_MIN, SCALE_MAX,
			24'sd0));
		t.insert(t.size(), make_xform(-32768, 0, 0, 0, SCALE_MIN, -24'sd1, 24'sd1));
		t.insert(t.size(), make_xform(2, 0, 0, 0, SCALE_MAX, SCALE_MIN, 24'sh123456));
		t.insert(t.size(), make_xform(2, 1, 0, 0, SCALE_MAX, SCALE_MIN, 24'sh123456));
		t.insert(t.size(), make_xform(1, 1, 1, 1, 24'sh010000, 24'sh010000, 24'sh010000));
		t.insert(t.size(), make_xform(1, 1, 1, 0, 24'sh010000, 24'sh010000, 24'sh010000));
		t.insert(t.size(), make_xform(8192, 8192, 8192, 8192, 24'sh7fffff, -24'sh7fffff,
			24'sh000001));
		t.insert(t.size(), make_xform(11585, 0, 0, 11585, 24'sh020000, 24'sh020000,
			24'sh020000));
		t.insert(t.size(), make_xform(-5, 7, -3, 2, 24'sh000001, -24'sh000001,
			24'sh000003));
		t.insert(t.size(), make_xform(32767, -32768, 1, -1, SCALE_MIN, SCALE_MIN,
			SCALE_MAX));
		t[0].mv = '{32'h7fffffff, 32'h80000000, 32'h0};
		t[1].mv = '{32'h80000000, 32'h7fffffff, 32'hffffffff};
		foreach (t[i])
			send_xform(t[i]);
		end_burst();
	endtask

	task automatic test_norm_limits();
		logic [LIMIT_BITS-1:0] limits[5] = '{32'd0, 32'hffffffff, 32'h10000000, 32'd5,
			32'd0};
		foreach (limits[k]) begin
			write_limit(k == 4 ? $urandom : limits[k]);
			send_xform(make_xform(0, 0, 0, 0, SCALE_MAX, SCALE_MIN, 24'sh010000));
			send_xform(make_xform(1, 0, 0, 0, SCALE_MIN, SCALE_MAX, 24'sh010000));
			send_xform(make_xform(2, 1, 0, 0, SCALE_MIN, SCALE_MAX, 24'sh010000));
			send_xform(make_xform(0, QONE, 0, 0, SCALE_MIN, SCALE_MIN, SCALE_MIN));
			send_xform(make_xform(0, 16383, 1, 0, SCALE_MIN, SCALE_MIN, SCALE_MIN));
			repeat (20) send_xform(rand_xform());
			end_burst();
		end
		write_limit(LIMIT_RESET);
	endtask

	task automatic test_random(int n);
		send_gaps = 1;
		recv_stalls = 1;
		repeat (n) send_xform(rand_xform());
		end_burst();
	endtask

	task automatic test_backpressure();
		@(posedge clk);
		hold_request = 400;
		repeat (120) send_xform(rand_xform());
		end_burst();
	endtask

	task automatic test_full_rate(int n);
		drain();
		send_gaps = 0;
		recv_stalls = 0;
		repeat (n) send_xform(rand_xform());
		end_burst();
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				out_ready <= 0;
				stall_left--;
			end else if (recv_stalls && $urandom_range(0, 7) == 0) begin
				out_ready <= 0;
				stall_left = $urandom_range(1, 19) - 1;
			end else begin
				out_ready <= arst_n;
			end
		end
	end

	always @(posedge clk) begin
		matrix_t m;
		logic [SB-1:0] got[NUM_ENT];
		logic [MOVE_BITS-1:0] got_mv[3];
		if (arst_n && out_valid && out_ready) begin
			beats_out++;
			if (pending_matrices.size() == 0) begin
				$error("result beat with no matrix expected");
				errors++;
			end else begin
				m = pending_matrices.pop_front();
				got = '{m11, m12, m13, m21, m22, m23, m31, m32, m33};
				got_mv = '{m41, m42, m43};
				for (int i = 0; i < NUM_ENT; i++)
					if (got[i] !== m.ent[i]) begin
						$error("%s expected %0d got %0d", ent_names[i],
							$signed(m.ent[i]), $signed(got[i]));
						errors++;
					end
				for (int i = 0; i < 3; i++)
					if (got_mv[i] !== m.mv[i]) begin
						$error("%s expected %0d got %0d", move_names[i],
							$signed(m.mv[i]), $signed(got_mv[i]));
						errors++;
					end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d matrices outstanding",
				STUCK_LIMIT, pending_matrices.size());
			$display("quaternion_trs_matrix_build_core_tb failed");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_norm_limits();
		test_random(900);
		test_backpressure();
		test_full_rate(200);
		drain();
		$display("%0d transforms in, %0d matrices out, %0d on the identity path",
			beats_in, beats_out, identity_hits);
		$display("%0d norm limit writes, random stalls on both sides and a long output hold",
			cfg_writes);
		if (errors == 0)
			$display("quaternion_trs_matrix_build_core_tb passed");
		else
			$display("quaternion_trs_matrix_build_core_tb failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/qtmb_pkg.sv
src/qtmb_recip_pipe.sv
src/quaternion_trs_matrix_build_core.sv
dv/quaternion_trs_matrix_build_core_tb.sv
